// ===== design/stoul_pkg.sv =====
`default_nettype none
package stoul_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int NUMBER_W    = 64;
	localparam int POS_W       = 16;
	localparam int BASE_W      = 6;
	localparam int DIGIT_W     = 6;
	localparam int PROD_W      = VALUE_WIDTH + BASE_W;

	localparam int FRONT_DEPTH = 4;
	localparam int FRONT_AW    = $clog2(FRONT_DEPTH);
	localparam int FRONT_CW    = FRONT_AW + 1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} stoul_in_t;

	typedef struct packed {
		logic [NUMBER_W-1:0] number;
		logic                overflowed;
		logic                any_digits;
		logic [POS_W-1:0]    end_offset;
	} stoul_out_t;

	// classified character, front to back
	typedef struct packed {
		logic               first;
		logic [BASE_W-1:0]  base;
		logic [POS_W-1:0]   pos;
		logic               is_blank;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               is_digit;
		logic [DIGIT_W-1:0] digit;
	} stoul_item_t;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} stoul_phase_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_DIGITS,
		ST_OVER
	} stoul_status_t;

endpackage
`default_nettype wire

// ===== design/stoul_front.sv =====
`default_nettype none
module stoul_front import stoul_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire stoul_in_t         char_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [BASE_W-1:0] cfg_data,
	output logic                   item_valid,
	output stoul_item_t            item,
	input  wire logic              item_take
);

	logic [BASE_W-1:0]   base_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    pos_cur;
	logic                accept;
	stoul_item_t         cls;
	stoul_item_t         mem_q [FRONT_DEPTH];
	logic [FRONT_AW-1:0] wr_q;
	logic [FRONT_AW-1:0] rd_q;
	logic [FRONT_CW-1:0] cnt_q;

	assign cfg_ready  = 1'b1;
	assign full       = (cnt_q == FRONT_CW'(FRONT_DEPTH));
	assign accept     = push && !full;
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_q];
	assign pos_cur    = char_data.first ? '0 : pos_q;

	always_comb begin
		logic [7:0] c;
		c = char_data.ch;
		cls          = '0;
		cls.first    = char_data.first;
		cls.base     = base_q;
		cls.pos      = pos_cur;
		cls.is_blank = (c == CH_SPACE);
		cls.is_plus  = (c == CH_PLUS);
		cls.is_minus = (c == CH_MINUS);
		cls.is_zero  = (c == CH_ZERO);
		cls.is_x     = (c == CH_LO_X) || (c == CH_UP_X);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			cls.is_digit = 1'b1;
			cls.digit    = DIGIT_W'(c - CH_ZERO);
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			cls.is_digit = 1'b1;
			cls.digit    = DIGIT_W'(c - CH_UP_A + 8'd10);
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			cls.is_digit = 1'b1;
			cls.digit    = DIGIT_W'(c - CH_LO_A + 8'd10);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_AUTO;
			pos_q  <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				base_q <= cfg_data;
			if (accept) begin
				pos_q <= (pos_cur != '1) ? pos_cur + POS_W'(1) : pos_cur;
				wr_q  <= wr_q + FRONT_AW'(1);
			end
			if (item_take)
				rd_q <= rd_q + FRONT_AW'(1);
			cnt_q <= cnt_q + FRONT_CW'(accept) - FRONT_CW'(item_take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mem_q[wr_q] <= cls;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FRONT_CW'(FRONT_DEPTH)) else $error("front queue count out of range");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cnt_q != '0) else $error("accepted transfer lost");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> item_valid) else $error("transfer taken from empty front queue");

endmodule
`default_nettype wire

// ===== design/stoul_back.sv =====
`default_nettype none
module stoul_back import stoul_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire stoul_item_t item,
	output logic             item_take,
	output logic             empty,
	input  wire logic        pop,
	output stoul_out_t       result
);

	stoul_phase_t            ph_q, ph_cur, ph_d;
	stoul_status_t           st_q, st_cur, st_f, st_d;
	logic                    neg_q, neg_cur, neg_d;
	logic [VALUE_WIDTH-1:0]  acc_q, acc_cur, acc_d, neg_val;
	logic [BASE_W-1:0]       eb_q, eb_cur, eb_f, eb_d, b;
	logic                    lead, lead_zero, feed, term, ovf, ends;
	logic [PROD_W-1:0]       prod;
	stoul_out_t              res_d;
	logic                    res_wr;

	stoul_out_t              oq_q [2];
	logic                    owr_q, ord_q;
	logic [1:0]              ocnt_q;

	assign item_take = item_valid && (ocnt_q != 2'd2);
	assign empty     = (ocnt_q == 2'd0);
	assign result    = oq_q[ord_q];

	assign ph_cur  = item.first ? PH_SKIP : ph_q;
	assign st_cur  = item.first ? ST_NONE : st_q;
	assign neg_cur = item.first ? 1'b0 : neg_q;
	assign acc_cur = item.first ? '0 : acc_q;
	assign eb_cur  = item.first ? item.base : eb_q;

	assign lead = (ph_cur == PH_SIGNED) || ((ph_cur == PH_SKIP) && !item.is_blank
		&& !item.is_plus && !item.is_minus);
	assign lead_zero = lead && item.is_zero && ((eb_cur == BASE_AUTO) || (eb_cur == BASE_HEX));
	assign feed = (lead && !lead_zero) || (ph_cur == PH_DIGITS)
		|| ((ph_cur == PH_ZERO) && !item.is_x);

	always_comb begin
		eb_f = eb_cur;
		if (eb_cur == BASE_AUTO) begin
			if (lead && !lead_zero)
				eb_f = BASE_DEC;
			else if (ph_cur == PH_ZERO)
				eb_f = BASE_OCT;
		end
	end

	// a held leading zero counts as a digit of value zero
	assign st_f = (ph_cur == PH_ZERO) ? ST_DIGITS : st_cur;
	assign b    = (eb_f == BASE_AUTO) ? BASE_DEC : eb_f;
	assign term = !item.is_digit || (item.digit >= b);
	assign prod = {{BASE_W{1'b0}}, acc_cur} * PROD_W'(b) + PROD_W'(item.digit);
	assign ovf  = |prod[PROD_W-1:VALUE_WIDTH];
	assign ends = item_take && feed && term;

	always_comb begin
		ph_d  = ph_cur;
		neg_d = neg_cur;
		acc_d = acc_cur;
		st_d  = st_cur;
		eb_d  = eb_f;
		case (ph_cur)
			PH_SKIP, PH_SIGNED: begin
				if (ph_cur == PH_SKIP && item.is_minus) begin
					neg_d = 1'b1;
					ph_d  = PH_SIGNED;
				end else if (ph_cur == PH_SKIP && item.is_plus) begin
					ph_d = PH_SIGNED;
				end else if (lead_zero) begin
					ph_d = PH_ZERO;
				end else if (lead) begin
					ph_d = term ? PH_DONE : PH_DIGITS;
				end
			end
			PH_ZERO: begin
				if (item.is_x) begin
					eb_d = BASE_HEX;
					ph_d = PH_DIGITS;
				end else begin
					st_d = st_f;
					ph_d = term ? PH_DONE : PH_DIGITS;
				end
			end
			PH_DIGITS: ph_d = term ? PH_DONE : PH_DIGITS;
			default:   ph_d = ph_cur;
		endcase
		if (feed && !term && st_f != ST_OVER) begin
			if (ovf) begin
				st_d  = ST_OVER;
				acc_d = '1;
			end else begin
				st_d  = ST_DIGITS;
				acc_d = prod[VALUE_WIDTH-1:0];
			end
		end
	end

	assign neg_val = ~acc_cur + VALUE_WIDTH'(1);

	always_comb begin
		res_wr           = ends;
		res_d.number     = NUMBER_W'((neg_cur && st_f == ST_DIGITS) ? neg_val : acc_cur);
		res_d.overflowed = (st_f == ST_OVER);
		res_d.any_digits = (st_f != ST_NONE);
		res_d.end_offset = (st_f != ST_NONE) ? item.pos : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SKIP;
			st_q   <= ST_NONE;
			neg_q  <= 1'b0;
			acc_q  <= '0;
			eb_q   <= BASE_AUTO;
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (item_take) begin
				ph_q  <= ph_d;
				st_q  <= st_d;
				neg_q <= neg_d;
				acc_q <= acc_d;
				eb_q  <= eb_d;
			end
			if (res_wr)
				owr_q <= ~owr_q;
			if (pop && !empty)
				ord_q <= ~ord_q;
			ocnt_q <= ocnt_q + 2'(res_wr) - 2'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr)
			oq_q[owr_q] <= res_d;
	end

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'd2) else $error("result queue overrun");

	a_ovf_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr && !res_d.any_digits |->
		!res_d.overflowed && res_d.number == '0 && res_d.end_offset == '0)
		else $error("result without digits not clean");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && !item.first && ph_q == PH_DONE |-> !res_wr)
		else $error("second result for one string");

endmodule
`default_nettype wire

// ===== design/string_to_unsigned_parser_unit.sv =====
`default_nettype none
// Channel    | Handshake                   | Payload
// input      | push / full                 | char_data (ch, first)
// result     | pop / empty                 | result (number, overflowed, any_digits, end_offset)
// config     | cfg_valid / cfg_ready       | cfg_data (base_select)
//
// One character per cycle sustained while the result queue has room; the accumulate step
// (64 x 6 multiply-add) is the back loop.
// A character's result passes through the front queue and the result queue to the result ports.
// Reset clears the parse state and base_select to 0; no clearing pass.
// A full result queue halts the back; the 4-entry front queue then fills and
// raises full.
module string_to_unsigned_parser_unit import stoul_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire stoul_in_t         char_data,
	output logic                   empty,
	input  wire logic              pop,
	output stoul_out_t             result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [BASE_W-1:0] cfg_data
);

	logic        item_valid;
	logic        item_take;
	stoul_item_t item;

	stoul_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_data  (char_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	stoul_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire

// ===== dv/tb_string_to_unsigned_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_string_to_unsigned_parser_unit;
	import stoul_pkg::*;

	localparam logic [NUMBER_W-1:0] ALL_ONES = {NUMBER_W{1'b1}} >> (NUMBER_W - VALUE_WIDTH);
	localparam logic [7:0] NOT_DIGIT = 8'hFF;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASE_CHARS = 180;
	localparam int MAX_REPORTS = 30;
	localparam int LIMIT = 2000000;

	typedef struct {
		bit                is_cfg;
		stoul_in_t         item;
		logic [BASE_W-1:0] base;
	} feed_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	stoul_in_t         char_data = '0;
	logic              empty;
	logic              pop = 1'b0;
	stoul_out_t        result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [BASE_W-1:0] cfg_data = '0;

	feed_t      feed_q[$];
	stoul_out_t results_due[$];

	// parser state as the block should hold it
	logic [BASE_W-1:0] base_sel = BASE_AUTO;
	stoul_phase_t      prs_phase = PH_SKIP;
	logic              prs_neg = 1'b0;
	logic [NUMBER_W-1:0] prs_acc = '0;
	stoul_status_t     prs_status = ST_NONE;
	logic [BASE_W-1:0] prs_base = BASE_AUTO;
	logic [POS_W-1:0]  prs_pos = '0;

	int queued_chars = 0;
	int chars_sent = 0;
	int results_seen = 0;
	int overflow_count = 0;
	int bare_count = 0;
	int bases_tried = 0;
	int errors = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int burst_left = 1;
	int settle = 0;
	int hold_left = 0;
	int pop_tick = 0;

	string_to_unsigned_parser_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_data (char_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] char_value(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return c - CH_ZERO;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			return c - CH_UP_A + 8'd10;
		if (c >= CH_LO_A && c <= CH_LO_Z)
			return c - CH_LO_A + 8'd10;
		return NOT_DIGIT;
	endfunction

	// one step of the digit loop; 1 means the byte ends the number
	function automatic bit take_digit(input logic [7:0] c);
		logic [7:0]          v;
		logic [NUMBER_W-1:0] b;
		logic [NUMBER_W-1:0] cutoff;
		logic [NUMBER_W-1:0] cutlim;
		v = char_value(c);
		b = (prs_base != BASE_AUTO) ? NUMBER_W'(prs_base) : NUMBER_W'(BASE_DEC);
		cutoff = ALL_ONES / b;
		cutlim = ALL_ONES % b;
		if (v == NOT_DIGIT || NUMBER_W'(v) >= b)
			return 1'b1;
		if (prs_status == ST_OVER)
			return 1'b0;
		if (prs_acc > cutoff || (prs_acc == cutoff && NUMBER_W'(v) > cutlim)) begin
			prs_status = ST_OVER;
			prs_acc = ALL_ONES;
		end else begin
			prs_status = ST_DIGITS;
			prs_acc = prs_acc * b + NUMBER_W'(v);
		end
		return 1'b0;
	endfunction

	function automatic bit take_lead(input logic [7:0] c);
		if ((prs_base == BASE_AUTO || prs_base == BASE_HEX) && c == CH_ZERO) begin
			prs_phase = PH_ZERO;
			return 1'b0;
		end
		if (prs_base == BASE_AUTO)
			prs_base = BASE_DEC;
		prs_phase = PH_DIGITS;
		return take_digit(c);
	endfunction

	task automatic parse_char(input stoul_in_t it);
		logic [POS_W-1:0] at;
		bit               ends;
		stoul_out_t       r;
		ends = 1'b0;
		if (it.first) begin
			prs_phase = PH_SKIP;
			prs_neg = 1'b0;
			prs_acc = '0;
			prs_status = ST_NONE;
			prs_base = base_sel;
			prs_pos = '0;
		end
		at = prs_pos;
		if (prs_pos != '1)
			prs_pos++;
		case (prs_phase)
			PH_SKIP: begin
				if (it.ch == CH_MINUS) begin
					prs_neg = 1'b1;
					prs_phase = PH_SIGNED;
				end else if (it.ch == CH_PLUS) begin
					prs_phase = PH_SIGNED;
				end else if (it.ch != CH_SPACE) begin
					ends = take_lead(it.ch);
				end
			end
			PH_SIGNED: ends = take_lead(it.ch);
			PH_ZERO: begin
				if (it.ch == CH_LO_X || it.ch == CH_UP_X) begin
					prs_base = BASE_HEX;
					prs_phase = PH_DIGITS;
				end else begin
					if (prs_base == BASE_AUTO)
						prs_base = BASE_OCT;
					prs_phase = PH_DIGITS;
					void'(take_digit(CH_ZERO));
					ends = take_digit(it.ch);
				end
			end
			PH_DIGITS: ends = take_digit(it.ch);
			default: ;
		endcase
		if (ends) begin
			r.number = ((prs_neg && prs_status == ST_DIGITS) ? -prs_acc : prs_acc) & ALL_ONES;
			r.overflowed = (prs_status == ST_OVER);
			r.any_digits = (prs_status != ST_NONE);
			r.end_offset = (prs_status != ST_NONE) ? at : '0;
			overflow_count += r.overflowed;
			bare_count += !r.any_digits;
			prs_phase = PH_DONE;
			results_due.push_back(r);
		end
	endtask

	task automatic put_char(input logic [7:0] c, input bit f);
		feed_t e;
		e.is_cfg = 1'b0;
		e.item.ch = c;
		e.item.first = f;
		e.base = '0;
		feed_q.push_back(e);
		queued_chars++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(8'(s[i]), i == 0);
	endtask

	task automatic put_base(input logic [BASE_W-1:0] b);
		feed_t e;
		e.is_cfg = 1'b1;
		e.item = '0;
		e.base = b;
		feed_q.push_back(e);
		bases_tried++;
	endtask

	// mostly well-formed strings with random content, some noise and abandoned ones
	task automatic add_string(input logic [BASE_W-1:0] b);
		int         radix;
		int         ndig;
		int         v;
		bit         f;
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			return;
		end
		radix = (b == BASE_AUTO) ? 10 : int'(b);
		f = 1'b1;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
			put_char(CH_SPACE, f);
			f = 1'b0;
		end
		case ($urandom_range(0, 3))
			0: begin
				put_char(CH_PLUS, f);
				f = 1'b0;
			end
			1: begin
				put_char(CH_MINUS, f);
				f = 1'b0;
			end
			default: ;
		endcase
		if (b == BASE_AUTO || b == BASE_HEX) begin
			case ($urandom_range(0, 3))
				0: begin
					put_char(CH_ZERO, f);
					put_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0);
					f = 1'b0;
					radix = 16;
				end
				1: begin
					put_char(CH_ZERO, f);
					f = 1'b0;
					if (b == BASE_AUTO)
						radix = 8;
				end
				default: ;
			endcase
		end
		ndig = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
		repeat (ndig) begin
			v = $urandom_range(0, (radix > 36 ? 36 : radix) - 1);
			if (v < 10)
				c = CH_ZERO + 8'(v);
			else
				c = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
			put_char(c, f);
			f = 1'b0;
		end
		if ($urandom_range(0, 9) == 0)
			return;
		do
			c = 8'($urandom_range(0, 255));
		while (char_value(c) != NOT_DIGIT && int'(char_value(c)) < radix);
		put_char(c, f);
		repeat ($urandom_range(0, 2))
			put_char(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (push && !full) begin
				parse_char(char_data);
				void'(feed_q.pop_front());
				chars_sent++;
				settle = 0;
			end
			if (cfg_valid && cfg_ready) begin
				base_sel = cfg_data;
				void'(feed_q.pop_front());
				settle = 0;
			end
			if (results_due.size() != 0)
				settle = 0;
			else if (settle < SETTLE_CYCLES)
				settle++;
			if (feed_q.size() == 0 || feed_q[0].is_cfg) begin
				push <= 1'b0;
				cfg_valid <= feed_q.size() != 0 && settle >= SETTLE_CYCLES;
				if (feed_q.size() != 0)
					cfg_data <= feed_q[0].base;
			end else begin
				cfg_valid <= 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					char_data <= feed_q[0].item;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		stoul_out_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$error("result transfer with nothing outstanding: number %0h",
							result.number);
				end else begin
					want = results_due.pop_front();
					check_field("number", want.number, result.number);
					check_field("overflowed", 64'(want.overflowed), 64'(result.overflowed));
					check_field("any_digits", 64'(want.any_digits), 64'(result.any_digits));
					check_field("end_offset", 64'(want.end_offset), 64'(result.end_offset));
				end
				results_seen++;
				if (results_seen == 30 || results_seen == 400)
					hold_left = HOLD_CYCLES;
			end
			pop_tick++;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case ((pop_tick / 64) % 4)
					0: pop <= 1'b1;
					1: pop <= $urandom_range(0, 3) != 0;
					2: pop <= (pop_tick % 5) != 0;
					default: pop <= $urandom_range(0, 2) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [BASE_W-1:0] phase_bases[10];
		int                target;
		phase_bases = '{BASE_AUTO, BASE_DEC, BASE_HEX, BASE_OCT, 6'd2, 6'd36, 6'd1, 6'd63,
			6'($urandom_range(3, 35)), BASE_AUTO};

		// after reset, no first flag: detect base
		put_char(CH_MINUS, 1'b0);
		put_char("7", 1'b0);
		put_char(8'h00, 1'b0);
		put_text("0xAf");
		put_char(8'hFF, 1'b0);
		put_text("0178");
		put_text("0xg");
		put_text("12");
		put_text(" 5 x");
		put_base(6'd36);
		put_text("-zzzzzzzzzzzzzz.");
		put_base(6'd1);
		put_text("+001");
		put_base(6'd63);
		put_text("Zz~");
		put_base(BASE_HEX);
		put_text("0XfF-");

		foreach (phase_bases[i]) begin
			put_base(phase_bases[i]);
			target = queued_chars + PHASE_CHARS;
			while (queued_chars < target)
				add_string(phase_bases[i]);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d characters across %0d base settings, checked %0d results",
			chars_sent, bases_tried, results_seen);
		$display("%0d saturated, %0d without digits, mismatches %0d",
			overflow_count, bare_count, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/stoul_pkg.sv
design/stoul_front.sv
design/stoul_back.sv
design/string_to_unsigned_parser_unit.sv
dv/tb_string_to_unsigned_parser_unit.sv
